FILE: rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg: shared constants for the SMA difference MACD core
// Ring depth, index and sum widths used by the core and its divider.
// ----------------------------------------------------------------------------
package smd_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int ADDR_W     = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
    localparam int PRICE_W    = 32;
    localparam int SUM_W      = PRICE_W + ADDR_W;
    localparam int WIN_W      = 7;
    localparam int MACD_W     = PRICE_W + 1;
    localparam int ITER_W     = $clog2(SUM_W + 1);

endpackage

FILE: rtl/smd_ram.sv
// ----------------------------------------------------------------------------
// smd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module smd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/smd_div.sv
// ----------------------------------------------------------------------------
// smd_div: iterative restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module smd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smd_pkg::SUM_W-1:0]   i_dividend,
    input  logic [smd_pkg::CNT_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [smd_pkg::PRICE_W-1:0] o_quotient
);
    import smd_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_dvs;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_quo[SUM_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= ITER_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - ITER_W'(1);
            if (r_cnt == ITER_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], fits};
            r_rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[PRICE_W-1:0];

endmodule

FILE: rtl/sma_difference_macd_core.sv
// ----------------------------------------------------------------------------
// sma_difference_macd_core: MACD from two simple moving averages
// Averages of past Q16.16 prices over two windows, and their difference.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one price each (tdata) and a series-start flag (tuser);
//   a start flag clears the sample count and the ring pointer first.
//   Each beat gives one output beat: MACD, short and long average (tdata)
//   and the warm-up flag (tuser).
//   Steps after acceptance: one ring read per sample in the larger active
//   window and a drain step (both skipped while neither window is warm),
//   two divisions on the shared restoring divider, then a load of the
//   output register.
//   One beat is in work at a time; s_tready is high only between items, so a
//   new beat is taken only once the last one has left the sequencer.
//   The output register holds a finished beat while the receiver stalls and
//   the next input beat is still taken; a second result then waits in the
//   core until the register frees up.
//   Reset clears the count, pointer and handshake state and loads windows of
//   12 and 26. Ring contents are undefined until written; no entry is read
//   before it is written in the current series.
//   Window registers sit on APB at byte 0 (short) and 4 (long).
// ----------------------------------------------------------------------------
module sma_difference_macd_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [31:0]   i_s_tdata,   // [31:0] price
    input  logic [0:0]    i_s_tuser,   // [0] series_start
    // output stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [103:0]  o_m_tdata,   // [32:0] macd_value, [64:33] short_average,
                                       // [96:65] long_average, [103:97] zero
    output logic [0:0]    o_m_tuser,   // [0] ready_res
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import smd_pkg::*;

    localparam int OUT_W = ((MACD_W + 2 * PRICE_W + 7) / 8) * 8;
    localparam int PAD_W = OUT_W - MACD_W - 2 * PRICE_W;
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    localparam logic [WIN_W-1:0] SHORT_RST = WIN_W'(12);
    localparam logic [WIN_W-1:0] LONG_RST  = WIN_W'(26);

    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIVS  = 3'd3;
    localparam logic [2:0] S_DIVL  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // zero acts as one, anything above the ring depth as the depth
    function automatic logic [CNT_W-1:0] clamp_win(input logic [WIN_W-1:0] w);
        logic [CMP_W-1:0] we;
        we = CMP_W'(w);
        if (w == '0) begin
            return CNT_W'(1);
        end
        if (we > CMP_W'(MAX_WINDOW)) begin
            return CNT_W'(MAX_WINDOW);
        end
        return CNT_W'(we);
    endfunction

    // control state
    logic [2:0]         r_state, n_state;
    logic [WIN_W-1:0]   r_sw, r_lw;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_wp, n_wp;
    logic               r_dv, n_dv;
    logic               r_div_start, n_div_start;
    logic               r_m_vld;

    // item payload
    logic [PRICE_W-1:0] r_price, n_price;
    logic [CNT_W-1:0]   r_csw, n_csw;
    logic [CNT_W-1:0]   r_clw, n_clw;
    logic               r_sen, n_sen;
    logic               r_len, n_len;
    logic [CNT_W-1:0]   r_rmax, n_rmax;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_dk, n_dk;
    logic [SUM_W-1:0]   r_sacc, n_sacc;
    logic [SUM_W-1:0]   r_lacc, n_lacc;
    logic [PRICE_W-1:0] r_savg, n_savg;
    logic [PRICE_W-1:0] r_lavg, n_lavg;
    logic [OUT_W-1:0]   r_m_data;
    logic               r_m_user;

    logic               in_acc;
    logic               cfg_wr;
    logic [CNT_W-1:0]   cfg_csw, cfg_clw;
    logic [CNT_W-1:0]   cnt_now;
    logic [CNT_W-1:0]   s_need, l_need, rmax_now;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [PRICE_W-1:0] ram_rdata;
    logic               div_done;
    logic [PRICE_W-1:0] div_q;
    logic [SUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    logic               out_load;
    logic [MACD_W-1:0]  macd;

    // ------------------------------------------------------------------
    // configuration port: decode on address bit 2, no wait states
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_SHORT: prdata = 32'(r_sw);
            REG_LONG:  prdata = 32'(r_lw);
            default:   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: read ring, divide short sum, divide long sum, store price
    // ------------------------------------------------------------------
    assign in_acc  = i_s_tvalid && o_s_tready;
    assign cfg_csw = clamp_win(r_sw);
    assign cfg_clw = clamp_win(r_lw);
    assign cnt_now = i_s_tuser[0] ? '0 : r_count;
    assign s_need  = (cnt_now >= cfg_csw) ? cfg_csw : '0;
    assign l_need  = (cnt_now >= cfg_clw) ? cfg_clw : '0;
    assign rmax_now = (s_need > l_need) ? s_need : l_need;

    // k-th most recent sample sits k entries behind the write pointer
    assign ram_raddr = r_wp - r_k[ADDR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wp        = r_wp;
        n_dv        = 1'b0;
        n_div_start = 1'b0;
        n_price     = r_price;
        n_csw       = r_csw;
        n_clw       = r_clw;
        n_sen       = r_sen;
        n_len       = r_len;
        n_rmax      = r_rmax;
        n_k         = r_k;
        n_dk        = r_dk;
        n_sacc      = r_sacc;
        n_lacc      = r_lacc;
        n_savg      = r_savg;
        n_lavg      = r_lavg;
        ram_we      = 1'b0;

        // fold in read data from the previous cycle's address
        if (r_dv) begin
            if (r_sen && (r_dk <= r_csw)) begin
                n_sacc = r_sacc + SUM_W'(ram_rdata);
            end
            if (r_len && (r_dk <= r_clw)) begin
                n_lacc = r_lacc + SUM_W'(ram_rdata);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_price = i_s_tdata[PRICE_W-1:0];
                    n_count = cnt_now;
                    n_wp    = i_s_tuser[0] ? '0 : r_wp;
                    n_csw   = cfg_csw;
                    n_clw   = cfg_clw;
                    n_sen   = cnt_now >= cfg_csw;
                    n_len   = cnt_now >= cfg_clw;
                    n_rmax  = rmax_now;
                    n_k     = CNT_W'(1);
                    n_sacc  = '0;
                    n_lacc  = '0;
                    // nothing to read before warm-up: divide zero sums
                    if (rmax_now == '0) begin
                        n_state     = S_DIVS;
                        n_div_start = 1'b1;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_dv = 1'b1;
                n_dk = r_k;
                n_k  = r_k + CNT_W'(1);
                if (r_k == r_rmax) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state     = S_DIVS;
                n_div_start = 1'b1;
            end
            S_DIVS: begin
                if (div_done) begin
                    n_savg      = div_q;
                    n_state     = S_DIVL;
                    n_div_start = 1'b1;
                end
            end
            S_DIVL: begin
                if (div_done) begin
                    n_lavg  = div_q;
                    ram_we  = 1'b1;
                    n_wp    = r_wp + ADDR_W'(1);
                    n_count = (r_count < CNT_W'(MAX_WINDOW)) ? r_count + CNT_W'(1)
                                                            : r_count;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_vld || i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    // ------------------------------------------------------------------
    // shared divider and history ring
    // ------------------------------------------------------------------
    assign div_dividend = (r_state == S_DIVS) ? r_sacc : r_lacc;
    assign div_divisor  = (r_state == S_DIVS) ? r_csw : r_clw;

    smd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    smd_ram #(
        .WIDTH (PRICE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_price),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // output register: load when empty or being drained
    // ------------------------------------------------------------------
    assign out_load = (r_state == S_OUT) && (!r_m_vld || i_m_tready);
    assign macd     = r_len ? ({1'b0, r_savg} - {1'b0, r_lavg}) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sw        <= SHORT_RST;
            r_lw        <= LONG_RST;
            r_count     <= '0;
            r_wp        <= '0;
            r_dv        <= 1'b0;
            r_div_start <= 1'b0;
            r_m_vld     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wp        <= n_wp;
            r_dv        <= n_dv;
            r_div_start <= n_div_start;
            if (cfg_wr && (paddr[2] == REG_SHORT)) begin
                r_sw <= pwdata[WIN_W-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_LONG)) begin
                r_lw <= pwdata[WIN_W-1:0];
            end
            if (out_load) begin
                r_m_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_csw   <= n_csw;
        r_clw   <= n_clw;
        r_sen   <= n_sen;
        r_len   <= n_len;
        r_rmax  <= n_rmax;
        r_k     <= n_k;
        r_dk    <= n_dk;
        r_sacc  <= n_sacc;
        r_lacc  <= n_lacc;
        r_savg  <= n_savg;
        r_lavg  <= n_lavg;
        if (out_load) begin
            r_m_data <= {PAD_W'(0), r_lavg, r_savg, macd};
            r_m_user <= r_len;
        end
    end

    assign o_m_tvalid   = r_m_vld;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser[0] = r_m_user;

`ifndef SYNTHESIS
    // sample count saturates at the ring depth
    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOW))
        else $error("sample count above ring depth");

    // divider finishes only while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVS || r_state == S_DIVL))
        else $error("divider done outside a divide step");

    // one item at a time: an accepted beat closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken twice in a row");

    // MACD stays zero before the long window has warmed up
    a_macd_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[MACD_W-1:0] == '0))
        else $error("MACD non-zero before warm-up");
`endif

endmodule

FILE: tb/sv/sma_macd_monitor.sv
// ----------------------------------------------------------------------------
// sma_macd_monitor: prediction and checking for the SMA difference MACD core
// Watches the APB port and both streams, keeps its own price ring and window
// registers, and checks every output beat against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sma_macd_monitor
    import smd_pkg::*;
#(
    parameter logic [2:0] SHORT_WIN_ADDR = 3'd0,
    parameter logic [2:0] LONG_WIN_ADDR  = 3'd4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [31:0]   i_s_tdata,   // [31:0] price
    input  logic [0:0]    i_s_tuser,   // [0] series_start
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [103:0]  i_m_tdata,   // [32:0] macd, [64:33] short, [96:65] long, pad
    input  logic [0:0]    i_m_tuser,   // [0] ready_res
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    input  logic          i_pready,
    output int            o_mismatches,
    output int            o_awaited
);

    localparam logic [WIN_W-1:0] SHORT_WIN_RESET = 7'd12;
    localparam logic [WIN_W-1:0] LONG_WIN_RESET  = 7'd26;

    typedef struct packed {
        logic [MACD_W-1:0]  macd;
        logic [PRICE_W-1:0] short_avg;
        logic [PRICE_W-1:0] long_avg;
        logic               warm;
    } averages_t;

    logic [PRICE_W-1:0] price_ring [MAX_WINDOW];
    logic [ADDR_W-1:0]  ring_ptr;
    logic [CNT_W-1:0]   seen;
    logic [WIN_W-1:0]   short_reg;
    logic [WIN_W-1:0]   long_reg;
    averages_t          awaited_averages [$];
    int                 mismatch_total;

    // zero acts as one, anything past the ring depth saturates
    function automatic logic [CNT_W-1:0] effective_window(input logic [WIN_W-1:0] w);
        if (w == '0)
            return CNT_W'(1);
        if (w > MAX_WINDOW)
            return CNT_W'(MAX_WINDOW);
        return w[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] trailing_sum(input logic [CNT_W-1:0] w);
        logic [SUM_W-1:0]  acc;
        logic [ADDR_W-1:0] idx;
        acc = '0;
        for (int k = 1; k <= w; k++) begin
            idx = ring_ptr - ADDR_W'(k);
            acc = acc + SUM_W'(price_ring[idx]);
        end
        return acc;
    endfunction

    // averages over the samples before this one, then store this one
    function automatic averages_t compute_averages(input logic [PRICE_W-1:0] price,
                                                   input logic start);
        logic [CNT_W-1:0] sw;
        logic [CNT_W-1:0] lw;
        averages_t        r;
        sw = effective_window(short_reg);
        lw = effective_window(long_reg);
        if (start) begin
            seen     = '0;
            ring_ptr = '0;
        end
        r = '0;
        if (seen >= sw)
            r.short_avg = PRICE_W'(trailing_sum(sw) / SUM_W'(sw));
        if (seen >= lw) begin
            r.long_avg = PRICE_W'(trailing_sum(lw) / SUM_W'(lw));
            r.warm     = 1'b1;
            r.macd     = {1'b0, r.short_avg} - {1'b0, r.long_avg};
        end
        price_ring[ring_ptr] = price;
        ring_ptr = ring_ptr + ADDR_W'(1);
        if (seen < MAX_WINDOW)
            seen = seen + CNT_W'(1);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [MACD_W-1:0] want,
                               input logic [MACD_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        averages_t want;
        if (!i_rst_n) begin
            ring_ptr       = '0;
            seen           = '0;
            short_reg      = SHORT_WIN_RESET;
            long_reg       = LONG_WIN_RESET;
            mismatch_total = 0;
            awaited_averages.delete();
            o_mismatches  <= 0;
            o_awaited     <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == SHORT_WIN_ADDR)
                    short_reg = i_pwdata[WIN_W-1:0];
                else if (i_paddr == LONG_WIN_ADDR)
                    long_reg = i_pwdata[WIN_W-1:0];
            end
            // retire before predicting: a beat leaving now belongs to an older sample
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_averages.size() == 0) begin
                    $display("%0t ns: unexpected output beat, expected none, actual %h/%h",
                             $time, i_m_tdata, i_m_tuser);
                    mismatch_total++;
                end else begin
                    want = awaited_averages.pop_front();
                    check_field("macd_value", want.macd, i_m_tdata[32:0]);
                    check_field("short_average", {1'b0, want.short_avg}, {1'b0, i_m_tdata[64:33]});
                    check_field("long_average", {1'b0, want.long_avg}, {1'b0, i_m_tdata[96:65]});
                    check_field("ready_res", {{MACD_W-1{1'b0}}, want.warm},
                                {{MACD_W-1{1'b0}}, i_m_tuser[0]});
                    check_field("tdata pad", '0, {{MACD_W-7{1'b0}}, i_m_tdata[103:97]});
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_averages.push_back(compute_averages(i_s_tdata, i_s_tuser[0]));
            o_awaited    <= awaited_averages.size();
            o_mismatches <= mismatch_total;
        end
    end

endmodule

FILE: tb/sv/sma_difference_macd_core_tb.sv
// ----------------------------------------------------------------------------
// sma_difference_macd_core_tb: stream and APB stimulus for the MACD core
// Directed warm-up and window corner cases, then random phases over a range
// of window settings and idling patterns; a monitor predicts and checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sma_difference_macd_core_tb;

    // register map of the window registers
    localparam logic [2:0] SHORT_WIN_ADDR = 3'd0;
    localparam logic [2:0] LONG_WIN_ADDR  = 3'd4;

    localparam int NUM_PHASES   = 12;
    localparam int PHASE_ITEMS  = 155;
    localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 200;   // beyond the worst latency of the core
    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat, no APB access

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_s_tvalid;
    logic          o_s_tready;
    logic [31:0]   i_s_tdata;   // [31:0] price
    logic [0:0]    i_s_tuser;   // [0] series_start
    logic          o_m_tvalid;
    logic          i_m_tready;
    logic [103:0]  o_m_tdata;   // [32:0] macd, [64:33] short, [96:65] long, pad
    logic [0:0]    o_m_tuser;   // [0] ready_res
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    int mismatch_count;
    int awaited;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_request;
    int quiet_cycles;
    int short_plan [10];
    int long_plan [10];

    sma_difference_macd_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    sma_macd_monitor #(
        .SHORT_WIN_ADDR (SHORT_WIN_ADDR),
        .LONG_WIN_ADDR  (LONG_WIN_ADDR)
    ) monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatch_count),
        .o_awaited    (awaited)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog: count cycles in which nothing moves on any port and give up
    // once the count passes anything a correct run could need.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("sma_difference_macd_core_tb: done, errors");
                $finish;
            end
        end
    end

    // Receiver: stall at random at the current rate; a hold-off request from
    // the stimulus overrides that and holds tready low for a counted stretch.
    initial begin
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Skew prices towards the extremes so that averages saturate and the
    // MACD swings to both ends; plain random words cover every bit.
    function automatic logic [31:0] draw_price();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'hFFFF_0000 | ($urandom & 32'h0000_FFFF);
            3:       return $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat, idling first at the sender rate. Return at the edge
    // that accepts it with tvalid still high; the next call either lowers
    // it or replaces the data, never both in one step.
    task automatic send_sample(input logic [31:0] price, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= price;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Drop tvalid and hold off until every predicted beat has come back.
    // Every sample yields a beat, so the core is idle once this returns.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (awaited != 0)
            @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_window(input logic [2:0] addr, input logic [6:0] width);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {25'd0, width};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int          phase;
        int          item;
        int          sw;
        int          lw;
        int          restart_pct;
        logic [31:0] warmup_prices [10];
        logic [31:0] skewed_prices [6];

        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 0;
        quiet_cycles   = 0;

        // window settings per random phase: defaults, both extremes, zero
        // and oversized values, short above long, equal windows
        short_plan = '{12, 1, 64, 0, 127, 5, 26, 65, 2, 33};
        long_plan  = '{26, 64, 1, 127, 0, 5, 12, 64, 2, 40};

        warmup_prices = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
        skewed_prices = '{32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF,
                          32'h8000_0000, 32'h0000_0001, 32'h0000_0007};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tiny windows, no series start since reset, so the stream
        // from reset is one series. Full-scale prices then zeros push both
        // averages to the top and drive the MACD negative and positive.
        write_window(SHORT_WIN_ADDR, 7'd2);
        write_window(LONG_WIN_ADDR, 7'd3);
        foreach (warmup_prices[k])
            send_sample(warmup_prices[k], 1'b0);

        // short window longer than long: MACD is minus the long average
        // until the short side warms up; open a fresh series here
        settle();
        write_window(SHORT_WIN_ADDR, 7'd5);
        write_window(LONG_WIN_ADDR, 7'd1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        foreach (skewed_prices[k])
            send_sample(skewed_prices[k], 1'b0);

        // zero window acts as one, oversized saturates; change mid-series
        settle();
        write_window(SHORT_WIN_ADDR, 7'd0);
        write_window(LONG_WIN_ADDR, 7'd127);
        repeat (3) send_sample(draw_price(), 1'b0);

        // shrink both windows mid-series: warm-up judged on the running count
        settle();
        write_window(SHORT_WIN_ADDR, 7'd4);
        write_window(LONG_WIN_ADDR, 7'd2);
        repeat (3) send_sample(draw_price(), 1'b0);

        // Random phases: mostly long series so the 64-deep windows warm up,
        // one phase of frequent restarts for broken series.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            if (phase < 10) begin
                sw = short_plan[phase];
                lw = long_plan[phase];
            end else begin
                sw = $urandom_range(127);
                lw = $urandom_range(127);
            end
            write_window(SHORT_WIN_ADDR, sw[6:0]);
            write_window(LONG_WIN_ADDR, lw[6:0]);

            case (phase % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 87;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 87;
                end
                default: begin
                    src_idle_pct   = 31;
                    sink_stall_pct = 31;
                end
            endcase
            restart_pct = (phase == 9) ? 30 : 2;

            for (item = 0; item < PHASE_ITEMS; item++) begin
                // receiver holds off while the sender keeps offering, so the
                // output register and the core fill and tready drops
                if (phase == 0 && item == 60)
                    hold_request = HOLD_CYCLES;
                // sender pauses until the core has emptied
                if (phase % 3 == 1 && item == 77)
                    settle();
                send_sample(draw_price(), $urandom_range(99) < restart_pct);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("sma_difference_macd_core_tb: done, clean");
        else
            $display("sma_difference_macd_core_tb: done, errors");
        $finish;
    end

endmodule
